@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants of the point-in-triangle pipeline.
// ----------------------------------------------------------------------------
package pit_pkg;

  // Number of register stages from the input word to the answer register.
  localparam int NSTAGE = 8;

  // Per-stage load enables, driven by the top-level flow control.
  typedef struct packed {
    logic res_en;   // stage 8: final compare, answer register
    logic sum_en;   // stage 7: un + vn, zero and sign flags
    logic diff_en;  // stage 6: den, un, vn
    logic wide_en;  // stage 5: partial products merged
    logic pp_en;    // stage 4: partial products of the wide multiplies
    logic dot_en;   // stage 3: dot product sums
    logic mul_en;   // stage 2: coordinate products
    logic sub_en;   // stage 1: edge vectors
  } ctl_t;

endpackage

@@ rtl/pit_query_if.sv @@
// ----------------------------------------------------------------------------
// pit_query_if
// Input channel: query point and three triangle vertices.
// ----------------------------------------------------------------------------
interface pit_query_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] vert_a_x;
  logic signed [COORD_WIDTH-1:0] vert_a_y;
  logic signed [COORD_WIDTH-1:0] vert_a_z;
  logic signed [COORD_WIDTH-1:0] vert_b_x;
  logic signed [COORD_WIDTH-1:0] vert_b_y;
  logic signed [COORD_WIDTH-1:0] vert_b_z;
  logic signed [COORD_WIDTH-1:0] vert_c_x;
  logic signed [COORD_WIDTH-1:0] vert_c_y;
  logic signed [COORD_WIDTH-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z,
    output vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
    output vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z,
    input  vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
    input  vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

@@ rtl/pit_answer_if.sv @@
// ----------------------------------------------------------------------------
// pit_answer_if
// Output channel: inside and degenerate flags for one query.
// ----------------------------------------------------------------------------
interface pit_answer_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (
    output valid, inside_res, degenerate,
    input  ready
  );

  modport sink (
    input  valid, inside_res, degenerate,
    output ready
  );
endinterface

@@ rtl/pit_front.sv @@
// ----------------------------------------------------------------------------
// pit_front
// Stages 1 to 3: edge vectors, coordinate products and the five dot products.
// ----------------------------------------------------------------------------
module pit_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                            clk,
  input  pit_pkg::ctl_t                   ctl,
  input  logic signed [COORD_WIDTH-1:0]   pnt [3],
  input  logic signed [COORD_WIDTH-1:0]   va  [3],
  input  logic signed [COORD_WIDTH-1:0]   vb  [3],
  input  logic signed [COORD_WIDTH-1:0]   vc  [3],
  output logic signed [2*COORD_WIDTH+2:0] d00,
  output logic signed [2*COORD_WIDTH+2:0] d01,
  output logic signed [2*COORD_WIDTH+2:0] d02,
  output logic signed [2*COORD_WIDTH+2:0] d11,
  output logic signed [2*COORD_WIDTH+2:0] d12
);
  localparam int EW = COORD_WIDTH + 1;  // edge vector component
  localparam int MW = 2 * EW;           // one coordinate product
  localparam int DW = MW + 1;           // sum of three products

  logic signed [EW-1:0] e0 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  logic signed [MW-1:0] m00 [3];
  logic signed [MW-1:0] m01 [3];
  logic signed [MW-1:0] m02 [3];
  logic signed [MW-1:0] m11 [3];
  logic signed [MW-1:0] m12 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (ctl.sub_en) begin
        e0[k] <= EW'(vc[k]) - EW'(va[k]);
        e1[k] <= EW'(vb[k]) - EW'(va[k]);
        e2[k] <= EW'(pnt[k]) - EW'(va[k]);
      end
      if (ctl.mul_en) begin
        m00[k] <= e0[k] * e0[k];
        m01[k] <= e0[k] * e1[k];
        m02[k] <= e0[k] * e2[k];
        m11[k] <= e1[k] * e1[k];
        m12[k] <= e1[k] * e2[k];
      end
    end
    if (ctl.dot_en) begin
      d00 <= DW'(m00[0]) + DW'(m00[1]) + DW'(m00[2]);
      d01 <= DW'(m01[0]) + DW'(m01[1]) + DW'(m01[2]);
      d02 <= DW'(m02[0]) + DW'(m02[1]) + DW'(m02[2]);
      d11 <= DW'(m11[0]) + DW'(m11[1]) + DW'(m11[2]);
      d12 <= DW'(m12[0]) + DW'(m12[1]) + DW'(m12[2]);
    end
  end

endmodule

@@ rtl/pit_wide_mul.sv @@
// ----------------------------------------------------------------------------
// pit_wide_mul
// Stages 4 and 5: signed multiply of two dot products, split into four
// half-width partial products that are merged one stage later.
// ----------------------------------------------------------------------------
module pit_wide_mul #(
  parameter int DW = 51
) (
  input  logic                   clk,
  input  pit_pkg::ctl_t          ctl,
  input  logic signed [DW-1:0]   a,
  input  logic signed [DW-1:0]   b,
  output logic signed [2*DW-1:0] prod
);
  localparam int LOW = DW / 2;     // unsigned low half
  localparam int HIW = DW - LOW;   // signed high half
  localparam int PW  = 2 * DW;

  logic signed [HIW-1:0] a_hi, b_hi;
  logic signed [LOW:0]   a_lo, b_lo;   // low half with a zero sign bit

  logic signed [2*HIW-1:0]   hh;
  logic signed [HIW+LOW:0]   hl;
  logic signed [HIW+LOW:0]   lh;
  logic signed [2*LOW+1:0]   ll;

  assign a_hi = a[DW-1:LOW];
  assign b_hi = b[DW-1:LOW];
  assign a_lo = $signed({1'b0, a[LOW-1:0]});
  assign b_lo = $signed({1'b0, b[LOW-1:0]});

  always_ff @(posedge clk) begin
    if (ctl.pp_en) begin
      hh <= a_hi * b_hi;
      hl <= a_hi * b_lo;
      lh <= a_lo * b_hi;
      ll <= a_lo * b_lo;
    end
    if (ctl.wide_en) begin
      prod <= (PW'(hh) <<< (2 * LOW)) + (PW'(hl) <<< LOW) + (PW'(lh) <<< LOW) + PW'(ll);
    end
  end

endmodule

@@ rtl/pit_decide.sv @@
// ----------------------------------------------------------------------------
// pit_decide
// Stages 6 to 8: denominator and barycentric numerators, then the inside
// and degenerate decisions.
// ----------------------------------------------------------------------------
module pit_decide #(
  parameter int FW = 102
) (
  input  logic                 clk,
  input  pit_pkg::ctl_t        ctl,
  input  logic signed [FW-1:0] p_d00_d11,
  input  logic signed [FW-1:0] p_d01_d01,
  input  logic signed [FW-1:0] p_d11_d02,
  input  logic signed [FW-1:0] p_d01_d12,
  input  logic signed [FW-1:0] p_d00_d12,
  input  logic signed [FW-1:0] p_d01_d02,
  output logic                 inside_res,
  output logic                 degenerate
);
  // Two guard bits cover un + vn and the final subtraction from den.
  localparam int RW = FW + 2;

  logic signed [RW-1:0] den, un, vn;
  logic signed [RW-1:0] den_q, uv_sum;
  logic                 deg_q, un_neg, vn_neg;
  logic signed [RW-1:0] slack;

  assign slack = den_q - uv_sum;

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      den <= RW'(p_d00_d11) - RW'(p_d01_d01);
      un  <= RW'(p_d11_d02) - RW'(p_d01_d12);
      vn  <= RW'(p_d00_d12) - RW'(p_d01_d02);
    end
    if (ctl.sum_en) begin
      den_q  <= den;
      uv_sum <= un + vn;
      deg_q  <= (den == '0);
      un_neg <= un[RW-1];
      vn_neg <= vn[RW-1];
    end
    if (ctl.res_en) begin
      inside_res <= !deg_q && !un_neg && !vn_neg && !slack[RW-1];
      degenerate <= deg_q;
    end
  end

endmodule

@@ rtl/point_in_triangle_test.sv @@
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Takes one query word per cycle unless stalled and answers each in order
// with one answer word. The eight register stages are the edge vectors, the
// coordinate products, the dot product sums, the partial products of the
// six wide multiplies, their merge, the numerator and denominator
// differences, the numerator sum with the zero and sign flags, and the
// final compare, whose register drives the answer channel. Every stage
// holds its word when the stage after it is full and stalled, so an empty
// stage anywhere lets a new query in even while an answer waits. A point
// on an edge or vertex counts as inside; a degenerate triangle is never
// inside and raises the degenerate flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_in_triangle_test #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  pit_query_if.sink           query,
  pit_answer_if.source        answer
);
  localparam int NS = pit_pkg::NSTAGE;
  localparam int DW = 2 * COORD_WIDTH + 3;
  localparam int FW = 2 * DW;

  logic [NS-1:0] vld;
  logic [NS:0]   load;
  logic [NS-1:0] vin;
  logic [NS-1:0] en;
  pit_pkg::ctl_t ctl;
  logic          in_acc, out_acc;

  logic signed [COORD_WIDTH-1:0] pnt [3];
  logic signed [COORD_WIDTH-1:0] va  [3];
  logic signed [COORD_WIDTH-1:0] vb  [3];
  logic signed [COORD_WIDTH-1:0] vc  [3];

  logic signed [DW-1:0] d00, d01, d02, d11, d12;
  logic signed [FW-1:0] p_d00_d11, p_d01_d01, p_d11_d02;
  logic signed [FW-1:0] p_d01_d12, p_d00_d12, p_d01_d02;

  // A stage loads when it is empty or its word moves on in the same cycle.
  always_comb begin
    load[NS] = answer.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign vin = {vld[NS-2:0], query.valid};
  assign en  = load[NS-1:0] & vin;
  assign ctl = pit_pkg::ctl_t'(en[NS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (load[i]) begin
          vld[i] <= vin[i];
        end
      end
    end
  end

  assign query.ready  = load[0];
  assign answer.valid = vld[NS-1];
  assign in_acc       = query.valid && query.ready;
  assign out_acc      = answer.valid && answer.ready;

  assign pnt[0] = query.point_x;
  assign pnt[1] = query.point_y;
  assign pnt[2] = query.point_z;
  assign va[0]  = query.vert_a_x;
  assign va[1]  = query.vert_a_y;
  assign va[2]  = query.vert_a_z;
  assign vb[0]  = query.vert_b_x;
  assign vb[1]  = query.vert_b_y;
  assign vb[2]  = query.vert_b_z;
  assign vc[0]  = query.vert_c_x;
  assign vc[1]  = query.vert_c_y;
  assign vc[2]  = query.vert_c_z;

  pit_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk (clk),
    .ctl (ctl),
    .pnt (pnt),
    .va  (va),
    .vb  (vb),
    .vc  (vc),
    .d00 (d00),
    .d01 (d01),
    .d02 (d02),
    .d11 (d11),
    .d12 (d12)
  );

  pit_wide_mul #(.DW(DW)) u_mul_den0 (
    .clk(clk), .ctl(ctl), .a(d00), .b(d11), .prod(p_d00_d11)
  );
  pit_wide_mul #(.DW(DW)) u_mul_den1 (
    .clk(clk), .ctl(ctl), .a(d01), .b(d01), .prod(p_d01_d01)
  );
  pit_wide_mul #(.DW(DW)) u_mul_un0 (
    .clk(clk), .ctl(ctl), .a(d11), .b(d02), .prod(p_d11_d02)
  );
  pit_wide_mul #(.DW(DW)) u_mul_un1 (
    .clk(clk), .ctl(ctl), .a(d01), .b(d12), .prod(p_d01_d12)
  );
  pit_wide_mul #(.DW(DW)) u_mul_vn0 (
    .clk(clk), .ctl(ctl), .a(d00), .b(d12), .prod(p_d00_d12)
  );
  pit_wide_mul #(.DW(DW)) u_mul_vn1 (
    .clk(clk), .ctl(ctl), .a(d01), .b(d02), .prod(p_d01_d02)
  );

  pit_decide #(
    .FW(FW)
  ) u_decide (
    .clk        (clk),
    .ctl        (ctl),
    .p_d00_d11  (p_d00_d11),
    .p_d01_d01  (p_d01_d01),
    .p_d11_d02  (p_d11_d02),
    .p_d01_d12  (p_d01_d12),
    .p_d00_d12  (p_d00_d12),
    .p_d01_d02  (p_d01_d02),
    .inside_res (answer.inside_res),
    .degenerate (answer.degenerate)
  );

  // The pipeline holds exactly the words accepted and not yet delivered.
  `ASSERT_CLK_RST(a_word_count, clk, rst, !$past(rst) |-> ($countones(vld) == $past($countones(vld)) + $past(int'(in_acc)) - $past(int'(out_acc))), "pipeline word count drifted")
  // Any empty stage must open the input.
  `ASSERT_CLK_RST(a_bubble_ready, clk, rst, !(&vld) |-> query.ready, "input blocked with an empty stage")
  // A degenerate triangle is never reported as inside.
  `ASSERT_CLK_RST(a_deg_not_inside, clk, rst, answer.valid |-> !(answer.inside_res && answer.degenerate), "degenerate answer marked inside")
  // Reset empties every stage.
  `ASSERT_CLK(a_rst_empty, clk, rst |=> (vld == '0), "stages not empty after reset")

endmodule

@@ dv/triangle_verdict_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_verdict_check
// Watches the query and answer channels of the point-in-triangle pipeline.
// Every accepted query word is turned into an expected verdict by an exact
// barycentric computation on 256-bit integers, and every accepted answer
// word is compared field by field with the oldest verdict still due.
// ----------------------------------------------------------------------------
module triangle_verdict_check #(
  parameter int COORD_WIDTH = 24
) (
  input  logic  clk,
  input  logic  rst,
  pit_query_if  query,
  pit_answer_if answer,
  output int    errors,
  output int    pending
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t                        vec3_t [3];
  typedef longint                        lvec_t [3];
  typedef logic signed [255:0]           wide_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } verdict_t;

  verdict_t verdicts_due [$];
  int       fail_count = 0;
  int       due_count  = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  function automatic wide_t dot3(input lvec_t x, input lvec_t y);
    wide_t acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + wide_t'(x[k]) * wide_t'(y[k]);
    end
    return acc;
  endfunction

  // Exact test: inside when den > 0, un >= 0, vn >= 0 and un + vn <= den.
  function automatic verdict_t barycentric_verdict(input vec3_t p, input vec3_t a,
                                                   input vec3_t b, input vec3_t c);
    lvec_t    edge_ca, edge_ba, to_pt;
    wide_t    d00, d01, d02, d11, d12, den, un, vn, slack;
    verdict_t v;
    for (int k = 0; k < 3; k++) begin
      edge_ca[k] = longint'(c[k]) - longint'(a[k]);
      edge_ba[k] = longint'(b[k]) - longint'(a[k]);
      to_pt[k]   = longint'(p[k]) - longint'(a[k]);
    end
    d00   = dot3(edge_ca, edge_ca);
    d01   = dot3(edge_ca, edge_ba);
    d02   = dot3(edge_ca, to_pt);
    d11   = dot3(edge_ba, edge_ba);
    d12   = dot3(edge_ba, to_pt);
    den   = d00 * d11 - d01 * d01;
    un    = d11 * d02 - d01 * d12;
    vn    = d00 * d12 - d01 * d02;
    slack = den - (un + vn);
    v.degenerate = (den == '0);
    v.inside_res = !v.degenerate && !un[255] && !vn[255] && !slack[255];
    return v;
  endfunction

  always @(posedge clk) begin
    vec3_t    p, a, b, c;
    verdict_t want;
    if (!rst) begin
      // Retire first: an answer word can never stem from a query of the same edge.
      if (answer.valid && answer.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("answer word accepted with no query outstanding");
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (answer.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0b, got %0b", want.inside_res, answer.inside_res);
            fail_count++;
          end
          if (answer.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0b, got %0b", want.degenerate, answer.degenerate);
            fail_count++;
          end
        end
      end
      if (query.valid && query.ready) begin
        p[0] = query.point_x;  p[1] = query.point_y;  p[2] = query.point_z;
        a[0] = query.vert_a_x; a[1] = query.vert_a_y; a[2] = query.vert_a_z;
        b[0] = query.vert_b_x; b[1] = query.vert_b_y; b[2] = query.vert_b_z;
        c[0] = query.vert_c_x; c[1] = query.vert_c_y; c[2] = query.vert_c_z;
        verdicts_due.push_back(barycentric_verdict(p, a, b, c));
      end
      due_count = verdicts_due.size();
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the point-in-triangle pipeline. A directed set
// covers vertices, edges, off-plane points, degenerate triangles and the
// coordinate extremes; random queries then mix constructed inside points,
// exact boundary points, collinear triangles, tiny coordinates and fully
// random words, sent in bursts against a randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb;

  localparam int     CW           = 24;
  localparam int     RANDOM_ITEMS = 1900;
  localparam longint CYCLE_LIMIT  = 1_000_000;
  localparam longint CMIN         = -(64'sd1 <<< (CW - 1));
  localparam longint CMAX         = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint ALT_LO       = 5592405;   // 0x555555
  localparam longint ALT_HI       = -5592406;  // 0xAAAAAA as signed

  typedef logic signed [CW-1:0] coord_t;

  logic   clk;
  logic   rst;
  int     fails;
  int     due;
  longint cycles = 0;

  pit_query_if #(.COORD_WIDTH(CW)) query ();
  pit_answer_if                    answer ();

  point_in_triangle_test #(.COORD_WIDTH(CW)) DUT (
    .clk    (clk),
    .rst    (rst),
    .query  (query),
    .answer (answer)
  );

  triangle_verdict_check #(.COORD_WIDTH(CW)) u_verdict_check (
    .clk     (clk),
    .rst     (rst),
    .query   (query),
    .answer  (answer),
    .errors  (fails),
    .pending (due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: each stretch picks its own stall behavior.
  initial begin
    int mode;
    int span;
    answer.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: begin
            answer.ready <= 1'b1;
          end
          1: begin
            answer.ready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            answer.ready <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            answer.ready <= ($urandom_range(0, 5) == 0);
          end
        endcase
      end
    end
  end

  function automatic longint rand_span(input int bits);
    return longint'($urandom_range(0, (32'd1 << (bits + 1)) - 1)) - (64'sd1 <<< bits);
  endfunction

  // Entered at a falling edge; returns at the falling edge after acceptance.
  task automatic send_query(input longint px, py, pz, ax, ay, az,
                            input longint bx, by, bz, cx, cy, cz);
    query.point_x  <= coord_t'(px);
    query.point_y  <= coord_t'(py);
    query.point_z  <= coord_t'(pz);
    query.vert_a_x <= coord_t'(ax);
    query.vert_a_y <= coord_t'(ay);
    query.vert_a_z <= coord_t'(az);
    query.vert_b_x <= coord_t'(bx);
    query.vert_b_y <= coord_t'(by);
    query.vert_b_z <= coord_t'(bz);
    query.vert_c_x <= coord_t'(cx);
    query.vert_c_y <= coord_t'(cy);
    query.vert_c_z <= coord_t'(cz);
    query.valid    <= 1'b1;
    do @(posedge clk); while (!query.ready);
    @(negedge clk);
  endtask

  task automatic send_random_query();
    longint a[3], e0[3], e1[3], p[3];
    int     sc, s, t, j, pick, k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // Point built from barycentric weights, with a little noise so
        // that some land just outside.
        sc = $urandom_range(2, 21);
        s  = $urandom_range(0, 1024);
        t  = $urandom_range(0, 1024 - s);
        k  = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++) begin
          a[i]  = rand_span(22);
          e1[i] = rand_span(sc);
          e0[i] = rand_span(sc);
          p[i]  = a[i] + (s * e1[i] + t * e0[i]) / 1024 + rand_span(k);
        end
        send_query(p[0], p[1], p[2], a[0], a[1], a[2],
                   a[0] + e1[0], a[1] + e1[1], a[2] + e1[2],
                   a[0] + e0[0], a[1] + e0[1], a[2] + e0[2]);
      end
      4, 5: begin
        // Exact vertex and edge points; edges are multiples of four.
        sc   = $urandom_range(1, 19);
        j    = $urandom_range(0, 4);
        pick = $urandom_range(0, 5);
        for (int i = 0; i < 3; i++) begin
          a[i]  = rand_span(22);
          e1[i] = rand_span(sc) * 4;
          e0[i] = rand_span(sc) * 4;
          case (pick)
            0: p[i] = a[i];
            1: p[i] = a[i] + e1[i];
            2: p[i] = a[i] + e0[i];
            3: p[i] = a[i] + e1[i] * j / 4;
            4: p[i] = a[i] + e0[i] * j / 4;
            default: p[i] = a[i] + e1[i] + (e0[i] - e1[i]) * j / 4;
          endcase
        end
        send_query(p[0], p[1], p[2], a[0], a[1], a[2],
                   a[0] + e1[0], a[1] + e1[1], a[2] + e1[2],
                   a[0] + e0[0], a[1] + e0[1], a[2] + e0[2]);
      end
      6: begin
        // Collinear or coincident vertices.
        sc = $urandom_range(0, 18);
        k  = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) begin
          a[i]  = rand_span(20);
          e1[i] = rand_span(sc);
          p[i]  = rand_span(22);
        end
        send_query(p[0], p[1], p[2], a[0], a[1], a[2],
                   a[0] + e1[0], a[1] + e1[1], a[2] + e1[2],
                   a[0] + k * e1[0], a[1] + k * e1[1], a[2] + k * e1[2]);
      end
      7: begin
        send_query(rand_span(3), rand_span(3), rand_span(3),
                   rand_span(3), rand_span(3), rand_span(3),
                   rand_span(3), rand_span(3), rand_span(3),
                   rand_span(3), rand_span(3), rand_span(3));
      end
      default: begin
        send_query(longint'($urandom), longint'($urandom), longint'($urandom),
                   longint'($urandom), longint'($urandom), longint'($urandom),
                   longint'($urandom), longint'($urandom), longint'($urandom),
                   longint'($urandom), longint'($urandom), longint'($urandom));
      end
    endcase
  endtask

  initial begin
    int  sent;
    int  burst;
    int  gap;
    bit  drained;
    rst <= 1'b1;
    query.valid    <= 1'b0;
    query.point_x  <= '0;
    query.point_y  <= '0;
    query.point_z  <= '0;
    query.vert_a_x <= '0;
    query.vert_a_y <= '0;
    query.vert_a_z <= '0;
    query.vert_b_x <= '0;
    query.vert_b_y <= '0;
    query.vert_b_z <= '0;
    query.vert_c_x <= '0;
    query.vert_c_y <= '0;
    query.vert_c_z <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words, sent back to back.
    send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_query(100, 100, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(0, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(1000, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(0, 1000, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(500, 500, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(501, 500, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(-1, 5, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(100, 100, CMAX, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(100, 100, CMIN, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_query(5, 5, 5, 0, 0, 0, 10, 10, 10, 20, 20, 20);
    send_query(9, 9, 9, 7, -3, 2, 7, -3, 2, 50, 1, 9);
    send_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    send_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    send_query(0, 0, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    send_query(-1, -1, 0, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    send_query(0, 0, 0, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN);
    send_query(ALT_LO, ALT_HI, ALT_LO, ALT_HI, ALT_LO, ALT_HI,
               ALT_LO, ALT_LO, ALT_HI, ALT_HI, ALT_HI, ALT_LO);
    send_query(-150, 0, 0, 0, 0, 0, 100, 0, 0, -300, 1, 0);

    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      // The first stretch runs with no sender gaps at all.
      gap   = (sent < 300) ? 0 : $urandom_range(0, 6);
      repeat (burst) begin
        send_random_query();
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        // Hold off until the pipeline has handed back every answer word.
        drained = 1'b1;
        query.valid <= 1'b0;
        do @(negedge clk); while (due != 0);
      end else if (gap > 0) begin
        query.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end

    query.valid <= 1'b0;
    while (due != 0) @(posedge clk);
    repeat (pit_pkg::NSTAGE * 4) @(posedge clk);
    if (fails == 0 && due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pit_pkg.sv
rtl/pit_query_if.sv
rtl/pit_answer_if.sv
rtl/pit_front.sv
rtl/pit_wide_mul.sv
rtl/pit_decide.sv
rtl/point_in_triangle_test.sv
dv/triangle_verdict_check.sv
dv/tb.sv
